/* src/rmfc_pkg.sv */
// shared types and constants for the range most-frequent-count block
package rmfc_pkg;

   localparam int VALUE_W = 32;
   localparam int INDEX_W = 13;
   localparam int FREQ_W  = 13;
   localparam int LOG_W   = 5;

   typedef enum logic [1:0] {
      OP_APPEND = 2'd0,
      OP_QUERY  = 2'd1,
      OP_REJECT = 2'd2
   } op_type;

   typedef struct packed {
      op_type                     op;
      logic signed [VALUE_W-1:0]  value;
      logic                       last_element;
      logic [INDEX_W-1:0]         left_index;
      logic [INDEX_W-1:0]         right_index;
   } item_type;

endpackage

/* src/rmfc_ram.sv */
// generic memory, one write port and one registered read port
module rmfc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

/* src/rmfc_front.sv */
// front end: takes items, classifies them and queues them for the back end
module rmfc_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic                        req_command,
   input  logic signed [31:0]          req_value,
   input  logic                        req_last_element,
   input  logic [12:0]                 req_left_index,
   input  logic [12:0]                 req_right_index,
   output logic                        q_valid,
   output rmfc_pkg::item_type          q_item,
   input  logic                        q_pop
);
   import rmfc_pkg::*;

   item_type   slot_ff [2];
   item_type   slot_in;
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] fill_ff, fill_in;
   logic       push;
   logic       pop;

   assign busy = (fill_ff == 2'd2);
   assign push = start && !busy;
   assign pop  = q_pop && (fill_ff != 2'd0);

   always_comb begin
      slot_in.value        = req_value;
      slot_in.last_element = req_last_element;
      slot_in.left_index   = req_left_index;
      slot_in.right_index  = req_right_index;
      if (!req_command) begin
         slot_in.op = OP_APPEND;
      end else if (req_left_index == '0 || req_left_index > req_right_index) begin
         slot_in.op = OP_REJECT;
      end else begin
         slot_in.op = OP_QUERY;
      end
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= slot_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   assign q_valid = (fill_ff != 2'd0);
   assign q_item  = slot_ff[rd_ptr_ff];
endmodule

/* src/rmfc_back.sv */
// back end: run bookkeeping, sparse table build and query sequencing
module rmfc_back #(
   parameter int MAX_ELEMENTS = 4096,
   parameter int TABLE_LEVELS = 13
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_valid,
   input  rmfc_pkg::item_type  q_item,
   output logic                q_pop,
   output logic                rsp_valid,
   output logic [12:0]         rsp_max_frequency,
   output logic                rsp_query_error
);
   import rmfc_pkg::*;

   localparam int IW   = $clog2(MAX_ELEMENTS);
   localparam int CW   = $clog2(MAX_ELEMENTS + 1);
   localparam int KW   = $clog2(TABLE_LEVELS);
   localparam int LD   = TABLE_LEVELS * MAX_ELEMENTS;
   localparam int AW   = $clog2(LD);
   localparam int CMPW = (CW > INDEX_W) ? CW : INDEX_W;

   typedef enum logic [10:0] {
      S_IDLE    = 11'b000_0000_0001,
      S_Q_RUN1  = 11'b000_0000_0010,
      S_Q_EDGE  = 11'b000_0000_0100,
      S_Q_ENDS  = 11'b000_0000_1000,
      S_Q_T0    = 11'b000_0001_0000,
      S_Q_T1    = 11'b000_0010_0000,
      S_Q_T2    = 11'b000_0100_0000,
      S_B_LEVEL = 11'b000_1000_0000,
      S_B_RD0   = 11'b001_0000_0000,
      S_B_RD1   = 11'b010_0000_0000,
      S_B_WR    = 11'b100_0000_0000
   } state_type;

   function automatic logic [LOG_W-1:0] floor_log2(input logic [IW-1:0] x);
      logic [LOG_W-1:0] lg;
      lg = '0;
      for (int i = 0; i < IW; i++) begin
         if (x[i]) begin
            lg = LOG_W'(i);
         end
      end
      return lg;
   endfunction

   function automatic logic [CW-1:0] max2(input logic [CW-1:0] a, input logic [CW-1:0] b);
      return (a > b) ? a : b;
   endfunction

   state_type                 state_ff, state_in;
   logic [CW-1:0]             cnt_ff, cnt_in;
   logic [CW-1:0]             rt_ff, rt_in;
   logic                      ready_ff, ready_in;
   logic signed [VALUE_W-1:0] prev_ff, prev_in;
   logic [CW-1:0]             len_ff, len_in;
   logic [IW-1:0]             l_ff, l_in;
   logic [IW-1:0]             r_ff, r_in;
   logic [IW-1:0]             rl_ff, rl_in;
   logic [IW-1:0]             rr_ff, rr_in;
   logic [CW-1:0]             ans_ff, ans_in;
   logic [CW-1:0]             tmp_ff, tmp_in;
   logic [KW-1:0]             lg_ff, lg_in;
   logic [KW-1:0]             k_ff, k_in;
   logic [CW-1:0]             j_ff, j_in;
   logic [CW:0]               spn_ff, spn_in;
   logic                      rsp_v_ff, rsp_v_in;
   logic [FREQ_W-1:0]         rsp_f_ff, rsp_f_in;
   logic                      rsp_e_ff, rsp_e_in;

   logic          rop_we, first_we, last_we, lvl_we;
   logic [IW-1:0] rop_wa, rop_wd, rop_ra, rop_rd;
   logic [IW-1:0] first_wa, first_wd, first_ra, first_rd;
   logic [IW-1:0] last_wa, last_wd, last_ra, last_rd;
   logic [AW-1:0] lvl_wa, lvl_ra;
   logic [CW-1:0] lvl_wd, lvl_rd;

   logic [CW-1:0]    cnt_eff, rt_eff, rt_new, len_new;
   logic             new_run;
   logic [IW-1:0]    run_idx;
   logic [IW-1:0]    rr_now;
   logic [LOG_W-1:0] lg_raw;
   logic [CW-1:0]    ends_a, ends_b;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      rt_in    = rt_ff;
      ready_in = ready_ff;
      prev_in  = prev_ff;
      len_in   = len_ff;
      l_in     = l_ff;
      r_in     = r_ff;
      rl_in    = rl_ff;
      rr_in    = rr_ff;
      ans_in   = ans_ff;
      tmp_in   = tmp_ff;
      lg_in    = lg_ff;
      k_in     = k_ff;
      j_in     = j_ff;
      spn_in   = spn_ff;
      rsp_v_in = 1'b0;
      rsp_f_in = rsp_f_ff;
      rsp_e_in = rsp_e_ff;
      q_pop    = 1'b0;

      rop_we   = 1'b0;
      first_we = 1'b0;
      last_we  = 1'b0;
      lvl_we   = 1'b0;
      rop_ra   = r_ff;
      first_ra = rr_ff;
      last_ra  = rl_ff;
      lvl_ra   = AW'(k_ff) * AW'(MAX_ELEMENTS) + AW'(j_ff);
      lvl_wa   = AW'(k_ff + KW'(1)) * AW'(MAX_ELEMENTS) + AW'(j_ff);
      lvl_wd   = max2(tmp_ff, lvl_rd);

      cnt_eff  = ready_ff ? '0 : cnt_ff;
      rt_eff   = ready_ff ? '0 : rt_ff;
      new_run  = (cnt_eff == '0) || (q_item.value != prev_ff);
      rt_new   = new_run ? rt_eff + CW'(1) : rt_eff;
      len_new  = new_run ? CW'(1) : len_ff + CW'(1);
      run_idx  = IW'(rt_new - CW'(1));
      rop_wa   = IW'(cnt_eff);
      rop_wd   = run_idx;
      first_wa = IW'(rt_eff);
      first_wd = IW'(cnt_eff);
      last_wa  = run_idx;
      last_wd  = IW'(cnt_eff);
      rr_now   = rop_rd;
      lg_raw   = floor_log2(rr_ff - rl_ff - IW'(1));
      ends_a   = CW'(last_rd) - CW'(l_ff) + CW'(1);
      ends_b   = CW'(r_ff) - CW'(first_rd) + CW'(1);

      unique case (state_ff)
         S_IDLE: begin
            rop_ra = IW'(q_item.left_index - INDEX_W'(1));
            if (q_valid) begin
               q_pop = 1'b1;
               unique case (q_item.op)
                  OP_APPEND: begin
                     ready_in = 1'b0;
                     cnt_in   = cnt_eff;
                     rt_in    = rt_eff;
                     if (cnt_eff >= CW'(MAX_ELEMENTS)) begin
                        rsp_v_in = 1'b1;
                        rsp_f_in = '0;
                        rsp_e_in = 1'b1;
                     end else begin
                        rop_we   = 1'b1;
                        first_we = new_run;
                        last_we  = 1'b1;
                        lvl_we   = 1'b1;
                        lvl_wa   = AW'(run_idx);
                        lvl_wd   = len_new;
                        rt_in    = rt_new;
                        len_in   = len_new;
                        prev_in  = q_item.value;
                        cnt_in   = cnt_eff + CW'(1);
                     end
                     if (q_item.last_element) begin
                        k_in     = '0;
                        spn_in   = (CW+1)'(1);
                        state_in = S_B_LEVEL;
                     end
                  end
                  OP_QUERY: begin
                     if (!ready_ff ||
                         CMPW'(q_item.right_index) > CMPW'(cnt_ff)) begin
                        rsp_v_in = 1'b1;
                        rsp_f_in = '0;
                        rsp_e_in = 1'b1;
                     end else begin
                        l_in     = IW'(q_item.left_index - INDEX_W'(1));
                        r_in     = IW'(q_item.right_index - INDEX_W'(1));
                        state_in = S_Q_RUN1;
                     end
                  end
                  default: begin
                     rsp_v_in = 1'b1;
                     rsp_f_in = '0;
                     rsp_e_in = 1'b1;
                  end
               endcase
            end
         end
         S_Q_RUN1: begin
            rop_ra   = r_ff;
            rl_in    = rop_rd;
            state_in = S_Q_EDGE;
         end
         S_Q_EDGE: begin
            last_ra  = rl_ff;
            first_ra = rr_now;
            rr_in    = rr_now;
            if (rl_ff == rr_now) begin
               rsp_v_in = 1'b1;
               rsp_f_in = FREQ_W'(CW'(r_ff) - CW'(l_ff) + CW'(1));
               rsp_e_in = 1'b0;
               state_in = S_IDLE;
            end else begin
               state_in = S_Q_ENDS;
            end
         end
         S_Q_ENDS: begin
            ans_in = max2(ends_a, ends_b);
            if (({1'b0, rl_ff} + (IW+1)'(1)) < {1'b0, rr_ff}) begin
               lg_in    = (32'(lg_raw) > TABLE_LEVELS - 1) ? KW'(TABLE_LEVELS - 1)
                                                           : KW'(lg_raw);
               state_in = S_Q_T0;
            end else begin
               rsp_v_in = 1'b1;
               rsp_f_in = FREQ_W'(max2(ends_a, ends_b));
               rsp_e_in = 1'b0;
               state_in = S_IDLE;
            end
         end
         S_Q_T0: begin
            lvl_ra   = AW'(lg_ff) * AW'(MAX_ELEMENTS) + AW'(rl_ff) + AW'(1);
            state_in = S_Q_T1;
         end
         S_Q_T1: begin
            tmp_in   = lvl_rd;
            lvl_ra   = AW'(lg_ff) * AW'(MAX_ELEMENTS) + AW'(rr_ff) - (AW'(1) << lg_ff);
            state_in = S_Q_T2;
         end
         S_Q_T2: begin
            rsp_v_in = 1'b1;
            rsp_f_in = FREQ_W'(max2(ans_ff, max2(tmp_ff, lvl_rd)));
            rsp_e_in = 1'b0;
            state_in = S_IDLE;
         end
         S_B_LEVEL: begin
            if ((32'(k_ff) + 1 < TABLE_LEVELS) && (spn_ff < (CW+1)'(rt_ff))) begin
               j_in     = '0;
               state_in = S_B_RD0;
            end else begin
               ready_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_B_RD0: begin
            state_in = S_B_RD1;
         end
         S_B_RD1: begin
            tmp_in   = lvl_rd;
            lvl_ra   = AW'(k_ff) * AW'(MAX_ELEMENTS) + AW'(j_ff) + AW'(spn_ff);
            state_in = S_B_WR;
         end
         S_B_WR: begin
            lvl_we = 1'b1;
            j_in   = j_ff + CW'(1);
            if ((CW+1)'(j_ff) + (CW+1)'(1) + spn_ff < (CW+1)'(rt_ff)) begin
               state_in = S_B_RD0;
            end else begin
               k_in     = k_ff + KW'(1);
               spn_in   = spn_ff << 1;
               state_in = S_B_LEVEL;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
         rt_ff    <= '0;
         ready_ff <= 1'b0;
         prev_ff  <= '0;
         rsp_v_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         rt_ff    <= rt_in;
         ready_ff <= ready_in;
         prev_ff  <= prev_in;
         rsp_v_ff <= rsp_v_in;
      end
   end

   always_ff @(posedge clock) begin
      len_ff   <= len_in;
      l_ff     <= l_in;
      r_ff     <= r_in;
      rl_ff    <= rl_in;
      rr_ff    <= rr_in;
      ans_ff   <= ans_in;
      tmp_ff   <= tmp_in;
      lg_ff    <= lg_in;
      k_ff     <= k_in;
      j_ff     <= j_in;
      spn_ff   <= spn_in;
      rsp_f_ff <= rsp_f_in;
      rsp_e_ff <= rsp_e_in;
   end

   rmfc_ram #(.WIDTH(IW), .DEPTH(MAX_ELEMENTS)) u_run_of (
      .clock(clock), .wr_en(rop_we), .wr_addr(rop_wa), .wr_data(rop_wd),
      .rd_addr(rop_ra), .rd_data(rop_rd)
   );

   rmfc_ram #(.WIDTH(IW), .DEPTH(MAX_ELEMENTS)) u_run_first (
      .clock(clock), .wr_en(first_we), .wr_addr(first_wa), .wr_data(first_wd),
      .rd_addr(first_ra), .rd_data(first_rd)
   );

   rmfc_ram #(.WIDTH(IW), .DEPTH(MAX_ELEMENTS)) u_run_last (
      .clock(clock), .wr_en(last_we), .wr_addr(last_wa), .wr_data(last_wd),
      .rd_addr(last_ra), .rd_data(last_rd)
   );

   rmfc_ram #(.WIDTH(CW), .DEPTH(LD)) u_level_max (
      .clock(clock), .wr_en(lvl_we), .wr_addr(lvl_wa), .wr_data(lvl_wd),
      .rd_addr(lvl_ra), .rd_data(lvl_rd)
   );

   assign rsp_valid         = rsp_v_ff;
   assign rsp_max_frequency = rsp_f_ff;
   assign rsp_query_error   = rsp_e_ff;

`ifndef ASSERT_OFF
   a_ok_needs_table: assert property (@(posedge clock) disable iff (reset)
      rsp_v_ff && !rsp_e_ff |-> ready_ff)
      else $error("good query answer without a built table");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_v_ff && rsp_e_ff |-> rsp_f_ff == '0)
      else $error("error answer with nonzero count");

   a_ready_from_build: assert property (@(posedge clock) disable iff (reset)
      $rose(ready_ff) |-> $past(state_ff) == S_B_LEVEL)
      else $error("table ready raised outside the build");
`endif
endmodule

/* src/range_most_frequent_count.sv */
// top level of the range most-frequent-count block
//
// channel  ports                      handshake
// -------  -------------------------  -----------------------------------
// request  req_*  (in)                taken when start is high, busy low
// result   rsp_*  (out)               one cycle, marked by rsp_valid
//
// append: done in S_IDLE; query: a chain of dependent registered memory reads
// last append starts a build: S_B_RD0, S_B_RD1, S_B_WR per entry, about N log N entries
// a two-item queue lets items arrive while the back end is working
// busy rises only when that queue is full; results cannot be held off
// reset clears counters and the table-ready flag, memories need no clearing
module range_most_frequent_count #(
   parameter int MAX_ELEMENTS = 4096,
   parameter int TABLE_LEVELS = 13
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic               req_command,
   input  logic signed [31:0] req_value,
   input  logic               req_last_element,
   input  logic [12:0]        req_left_index,
   input  logic [12:0]        req_right_index,
   output logic               rsp_valid,
   output logic [12:0]        rsp_max_frequency,
   output logic               rsp_query_error
);
   import rmfc_pkg::*;

   logic     q_valid;
   logic     q_pop;
   item_type q_item;

   rmfc_front u_front (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_command(req_command), .req_value(req_value),
      .req_last_element(req_last_element), .req_left_index(req_left_index),
      .req_right_index(req_right_index),
      .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop)
   );

   rmfc_back #(.MAX_ELEMENTS(MAX_ELEMENTS), .TABLE_LEVELS(TABLE_LEVELS)) u_back (
      .clock(clock), .reset(reset),
      .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop),
      .rsp_valid(rsp_valid), .rsp_max_frequency(rsp_max_frequency),
      .rsp_query_error(rsp_query_error)
   );
endmodule

/* sim/range_most_frequent_count_tb.sv */
// self-checking testbench for the range most-frequent-count block
module range_most_frequent_count_tb;
   import rmfc_pkg::*;

   localparam int  CAPACITY    = 4096;
   localparam int  LEVELS      = 13;
   localparam logic CMD_APPEND = 1'b0;
   localparam logic CMD_QUERY  = 1'b1;

   typedef struct packed {
      logic [FREQ_W-1:0] freq;
      logic              err;
   } answer_type;

   typedef struct {
      logic               cmd;
      logic [31:0]        value;
      logic               last;
      logic [12:0]        left;
      logic [12:0]        right;
      logic               fixed;
      logic [FREQ_W-1:0]  freq;
      logic               err;
   } dir_row_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic               req_command = 1'b0;
   logic signed [31:0] req_value = '0;
   logic               req_last_element = 1'b0;
   logic [12:0]        req_left_index = '0;
   logic [12:0]        req_right_index = '0;
   logic               rsp_valid;
   logic [12:0]        rsp_max_frequency;
   logic               rsp_query_error;

   answer_type answers_due[$];
   int      mismatches = 0;
   int      items_sent = 0;
   bit      steady_mode = 0;
   bit      first_item = 1;

   // predictor state
   logic [31:0]       prev_value;
   int                elem_count, run_count;
   bit                built;
   logic [11:0]       run_of [CAPACITY];
   logic [11:0]       run_first [CAPACITY];
   logic [11:0]       run_last [CAPACITY];
   logic [FREQ_W-1:0] level_max [LEVELS][CAPACITY];

   dir_row_type dir_rows [22] = '{
      '{CMD_QUERY,  32'd0,        1'b0, 13'd1,    13'd1,    1'b1, 13'd0, 1'b1},
      '{CMD_APPEND, 32'h80000000, 1'b0, 13'd0,    13'd0,    1'b0, 13'd0, 1'b0},
      '{CMD_APPEND, 32'h80000000, 1'b0, 13'd0,    13'd0,    1'b0, 13'd0, 1'b0},
      '{CMD_APPEND, 32'd5,        1'b0, 13'd0,    13'd0,    1'b0, 13'd0, 1'b0},
      '{CMD_APPEND, 32'd5,        1'b0, 13'h1fff, 13'h1fff, 1'b0, 13'd0, 1'b0},
      '{CMD_APPEND, 32'd5,        1'b0, 13'd0,    13'd0,    1'b0, 13'd0, 1'b0},
      '{CMD_APPEND, 32'd7,        1'b0, 13'd0,    13'd0,    1'b0, 13'd0, 1'b0},
      '{CMD_APPEND, 32'h7fffffff, 1'b1, 13'd0,    13'd0,    1'b0, 13'd0, 1'b0},
      '{CMD_QUERY,  32'hffffffff, 1'b1, 13'd1,    13'd7,    1'b1, 13'd3, 1'b0},
      '{CMD_QUERY,  32'd0,        1'b0, 13'd1,    13'd1,    1'b1, 13'd1, 1'b0},
      '{CMD_QUERY,  32'd0,        1'b0, 13'd2,    13'd6,    1'b0, 13'd0, 1'b0},
      '{CMD_QUERY,  32'd0,        1'b0, 13'd0,    13'd3,    1'b1, 13'd0, 1'b1},
      '{CMD_QUERY,  32'd0,        1'b0, 13'd3,    13'd8,    1'b1, 13'd0, 1'b1},
      '{CMD_QUERY,  32'd0,        1'b0, 13'd5,    13'd4,    1'b1, 13'd0, 1'b1},
      '{CMD_QUERY,  32'd0,        1'b0, 13'h1fff, 13'h1fff, 1'b1, 13'd0, 1'b1},
      '{CMD_QUERY,  32'd0,        1'b0, 13'd1,    13'h1fff, 1'b1, 13'd0, 1'b1},
      '{CMD_QUERY,  32'd0,        1'b0, 13'd7,    13'd7,    1'b1, 13'd1, 1'b0},
      '{CMD_QUERY,  32'd0,        1'b0, 13'd3,    13'd7,    1'b0, 13'd0, 1'b0},
      '{CMD_APPEND, 32'd100,      1'b0, 13'd0,    13'd0,    1'b0, 13'd0, 1'b0},
      '{CMD_QUERY,  32'd0,        1'b0, 13'd1,    13'd1,    1'b1, 13'd0, 1'b1},
      '{CMD_APPEND, 32'd100,      1'b1, 13'd0,    13'd0,    1'b0, 13'd0, 1'b0},
      '{CMD_QUERY,  32'd0,        1'b0, 13'd1,    13'd2,    1'b1, 13'd2, 1'b0}
   };

   range_most_frequent_count dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_command(req_command), .req_value(req_value),
      .req_last_element(req_last_element), .req_left_index(req_left_index),
      .req_right_index(req_right_index), .rsp_valid(rsp_valid),
      .rsp_max_frequency(rsp_max_frequency), .rsp_query_error(rsp_query_error)
   );

   always #6 clock = ~clock;

   initial begin
      #(12 * 3000000);
      $display("[FAIL] regression broken");
      $finish;
   end

   task automatic report_mismatch(input string what);
      mismatches++;
      $display("mismatch at %0t: %s", $realtime, what);
   endtask

   function automatic int floor_log2(input int x);
      int lg;
      lg = 0;
      while (x > 1) begin
         x = x >> 1;
         lg++;
      end
      return lg;
   endfunction

   function automatic void build_levels();
      int span;
      for (int j = 0; j < run_count; j++)
         level_max[0][j] = FREQ_W'(int'(run_last[j]) - int'(run_first[j]) + 1);
      for (int k = 0; k + 1 < LEVELS; k++) begin
         span = 1 << k;
         for (int j = 0; j + span < run_count; j++)
            level_max[k+1][j] = (level_max[k][j] > level_max[k][j+span]) ?
                                level_max[k][j] : level_max[k][j+span];
      end
   endfunction

   // returns 1 when the item yields an answer
   function automatic bit predict_answer(input logic cmd, input logic [31:0] val,
                                         input logic last, input int left,
                                         input int right, output answer_type ans);
      int l, r, rl, rr, best, lg, a, b;
      bit produced;
      ans = '{freq: '0, err: 1'b1};
      produced = 0;
      if (cmd == CMD_APPEND) begin
         if (built) begin
            built = 0;
            elem_count = 0;
            run_count = 0;
         end
         if (elem_count >= CAPACITY) begin
            produced = 1;
         end else begin
            if (elem_count == 0 || val != prev_value) begin
               run_first[run_count] = 12'(elem_count);
               run_count++;
            end
            run_of[elem_count] = 12'(run_count - 1);
            run_last[run_count-1] = 12'(elem_count);
            prev_value = val;
            elem_count++;
         end
         if (last && elem_count > 0) begin
            build_levels();
            built = 1;
         end
         return produced;
      end
      if (!built || left == 0 || right > elem_count || left > right) return 1;
      l = left - 1;
      r = right - 1;
      rl = int'(run_of[l]);
      rr = int'(run_of[r]);
      if (rl == rr) begin
         best = r - l + 1;
      end else begin
         best = int'(run_last[rl]) - l + 1;
         if (r - int'(run_first[rr]) + 1 > best) best = r - int'(run_first[rr]) + 1;
         if (rl + 1 < rr) begin
            a = rl + 1;
            b = rr - 1;
            lg = floor_log2(b - a + 1);
            if (lg > LEVELS - 1) lg = LEVELS - 1;
            if (int'(level_max[lg][a]) > best) best = int'(level_max[lg][a]);
            if (int'(level_max[lg][b-(1<<lg)+1]) > best)
               best = int'(level_max[lg][b-(1<<lg)+1]);
         end
      end
      ans = '{freq: best[FREQ_W-1:0], err: 1'b0};
      return 1;
   endfunction

   function automatic int pick_gap();
      int roll;
      if (steady_mode) return 0;
      roll = int'($urandom_range(0, 99));
      if (roll < 70) return int'($urandom_range(0, 2));
      if (roll < 95) return int'($urandom_range(3, 8));
      return int'($urandom_range(20, 60));
   endfunction

   // drives one item, waits for it to be taken, queues its answer when it yields one
   task automatic send_item(input logic cmd, input logic [31:0] val, input logic last,
                            input logic [12:0] left, input logic [12:0] right,
                            input bit fixed, input answer_type fixed_ans);
      int gap;
      answer_type ans;
      bit has;
      gap = first_item ? 0 : pick_gap();
      first_item = 0;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_command <= cmd;
      req_value <= val;
      req_last_element <= last;
      req_left_index <= left;
      req_right_index <= right;
      do @(posedge clock); while (busy);
      has = predict_answer(cmd, val, last, int'(left), int'(right), ans);
      if (fixed) ans = fixed_ans;
      if (has) answers_due = {answers_due, ans};
      items_sent++;
   endtask

   task automatic send_query(input int n);
      int l, r;
      if ($urandom_range(0, 9) == 0) begin
         l = int'($urandom_range(0, 8191));
         r = int'($urandom_range(0, 8191));
      end else begin
         l = int'($urandom_range(1, n));
         r = int'($urandom_range(l, n));
      end
      send_item(CMD_QUERY, $urandom, 1'($urandom_range(0, 1)), 13'(l), 13'(r), 1'b0, '0);
   endtask

   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (answers_due.size() > 0) @(posedge clock);
   endtask

   // loads n + extra nondecreasing values with some queries mixed in, then asks queries about them
   task automatic run_phase(input int n, input int extra, input int queries);
      logic [31:0] v;
      longint step;
      v = $urandom;
      if ($urandom_range(0, 1)) v = v ^ 32'h80000000;
      for (int i = 0; i < n + extra; i++) begin
         if ($urandom_range(0, 19) == 0) send_query(n);
         if (i > 0 && $urandom_range(0, 9) >= 6) begin
            step = ($urandom_range(0, 7) == 0) ? longint'($urandom)
                                               : longint'($urandom_range(1, 3));
            if ($signed(v) + step <= 64'sd2147483647) v = v + step[31:0];
         end
         send_item(CMD_APPEND, v, i == n + extra - 1, 13'($urandom), 13'($urandom),
                   1'b0, '0);
      end
      for (int q = 0; q < queries; q++) send_query(n);
      if ($urandom_range(0, 3) == 0) drain();
   endtask

   always @(posedge clock) begin
      answer_type want;
      if (!reset && rsp_valid) begin
         if (answers_due.size() == 0) begin
            report_mismatch("answer with nothing expected");
         end else begin
            want = answers_due.pop_front();
            if (rsp_max_frequency !== want.freq)
               report_mismatch($sformatf("max_frequency %0d, expected %0d",
                                         rsp_max_frequency, want.freq));
            if (rsp_query_error !== want.err)
               report_mismatch($sformatf("query_error %0b, expected %0b",
                                         rsp_query_error, want.err));
         end
      end
   end

   initial begin
      answer_type fixed_ans;
      prev_value = '0;
      elem_count = 0;
      run_count = 0;
      built = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_rows[i]) begin
         fixed_ans = '{freq: dir_rows[i].freq, err: dir_rows[i].err};
         send_item(dir_rows[i].cmd, dir_rows[i].value, dir_rows[i].last,
                   dir_rows[i].left, dir_rows[i].right, dir_rows[i].fixed, fixed_ans);
      end
      drain();

      run_phase(500, 0, 60);
      drain();
      while (items_sent < 1350) begin
         steady_mode = ($urandom_range(0, 4) == 0);
         if ($urandom_range(0, 19) == 0)
            run_phase(int'($urandom_range(100, 300)), 0, 40);
         else
            run_phase(int'($urandom_range(1, 40)), 0, int'($urandom_range(5, 30)));
      end

      drain();
      repeat (200) @(posedge clock);
      if (mismatches == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end
endmodule
